// File: sv/kwm_pkg.sv
// Package for the k-way sorted merge: shared constants and the queue entry type.
// Used by every module of the block but kwm_ram; no dependencies.
package kwm_pkg;

    localparam int DEF_NUM_LISTS   = 8;
    localparam int DEF_VALUE_WIDTH = 32;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int TDATA_W = 40;

    localparam logic [3:0] LISTS_RESET      = 4'd8;
    localparam logic       REG_LISTS_IN_USE = 1'b0;

    typedef struct packed {
        logic [2:0]  list_index;
        logic [31:0] element_value;
        logic        end_of_list;
        logic        in_range;
    } kwm_item_t;

endpackage

// File: sv/kwm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module kwm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/kwm_front.sv
// Front end of the merge: accepts stream transactions, checks the list range
// and queues them for the back end. Depends on kwm_pkg.
module kwm_front
    import kwm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // list_index[2:0], element_value[34:3], zeros
    input  logic               s_tlast,   // end_of_list
    input  logic [3:0]         active_count,
    output kwm_item_t          item,
    output logic               item_valid,
    input  logic               item_pop
);

    kwm_item_t          q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W:0]    count_reg;
    logic               push;
    logic               pop;
    kwm_item_t          new_item;

    assign s_tready   = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign push       = s_tvalid && s_tready;
    assign item_valid = (count_reg != '0);
    assign pop        = item_pop && item_valid;
    assign item       = q_reg[rd_ptr_reg];

    always_comb
    begin
        new_item.list_index    = s_tdata[2:0];
        new_item.element_value = s_tdata[34:3];
        new_item.end_of_list   = s_tlast;
        new_item.in_range      = ({1'b0, s_tdata[2:0]} < active_count);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: sv/kwm_back.sv
// Back end of the merge: applies queued transactions to the head slots, scans
// the slots with one comparator and drives the output register.
// Depends on kwm_pkg and kwm_ram.
module kwm_back
    import kwm_pkg::*;
#(
    parameter int NUM_LISTS   = DEF_NUM_LISTS,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  kwm_item_t          item,
    input  logic               item_valid,
    output logic               item_pop,
    input  logic [3:0]         active_count,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // merged_value[31:0], source_list[34:32], zeros
    output logic               m_tuser    // merge_done
);

    localparam int IDX_W = $clog2(NUM_LISTS);
    localparam int KW    = IDX_W + 1;
    localparam int EXT_W = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic [NUM_LISTS-1:0]   present_reg, present_next;
    logic [NUM_LISTS-1:0]   ended_reg, ended_next;
    logic [KW-1:0]          k_reg, k_next;
    logic                   any_reg, any_next;
    logic                   done_reg, done_next;
    logic [VALUE_WIDTH-1:0] best_val_reg, best_val_next;
    logic [IDX_W-1:0]       best_idx_reg, best_idx_next;

    logic                   out_valid_reg, out_valid_next;
    logic                   out_load;
    logic [31:0]            out_val_reg;
    logic [2:0]             out_src_reg;
    logic                   out_done_reg;
    logic [31:0]            out_val_new;
    logic [2:0]             out_src_new;

    logic [NUM_LISTS-1:0]   active_mask;
    logic                   all_ready;
    logic                   any_head;
    logic [IDX_W-1:0]       slot;
    logic [IDX_W-1:0]       prev;
    logic                   ram_we;
    logic [VALUE_WIDTH-1:0] ram_rdata;
    logic signed [EXT_W-1:0] in_ext;
    logic signed [EXT_W-1:0] best_ext;

    for (genvar g = 0; g < NUM_LISTS; g++)
    begin : g_mask
        assign active_mask[g] = (g < int'(active_count));
    end

    assign all_ready = &(present_reg | ended_reg | ~active_mask);
    assign any_head  = |(present_reg & active_mask);
    assign slot      = IDX_W'(item.list_index);
    assign prev      = IDX_W'(k_reg - 1'b1);
    assign in_ext    = EXT_W'(signed'(item.element_value));
    assign best_ext  = EXT_W'(signed'(best_val_reg));

    kwm_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (NUM_LISTS)
    ) u_heads (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot),
        .wdata (in_ext[VALUE_WIDTH-1:0]),
        .raddr (k_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        present_next   = present_reg;
        ended_next     = ended_reg;
        k_next         = k_reg;
        any_next       = any_reg;
        done_next      = done_reg;
        best_val_next  = best_val_reg;
        best_idx_next  = best_idx_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_load       = 1'b0;
        out_val_new    = best_ext[31:0];
        out_src_new    = 3'(best_idx_reg);
        item_pop       = 1'b0;
        ram_we         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    item_pop = 1'b1;
                    if (item.in_range && !ended_reg[slot])
                    begin
                        if (item.end_of_list)
                        begin
                            ended_next[slot] = 1'b1;
                        end
                        else if (!present_reg[slot])
                        begin
                            ram_we             = 1'b1;
                            present_next[slot] = 1'b1;
                        end
                    end
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!all_ready)
                begin
                    state_next = ST_IDLE;
                end
                else if (!any_head)
                begin
                    done_next  = 1'b1;
                    state_next = ST_EMIT;
                end
                else
                begin
                    done_next  = 1'b0;
                    any_next   = 1'b0;
                    k_next     = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if ((k_reg != '0) && present_reg[prev])
                begin
                    if (!any_reg || ($signed(ram_rdata) < $signed(best_val_reg)))
                    begin
                        best_val_next = ram_rdata;
                        best_idx_next = prev;
                    end
                    any_next = 1'b1;
                end
                if (int'(k_reg) == int'(active_count))
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    if (done_reg)
                    begin
                        out_val_new  = '0;
                        out_src_new  = '0;
                        present_next = '0;
                        ended_next   = '0;
                    end
                    else
                    begin
                        present_next[best_idx_reg] = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            present_reg   <= '0;
            ended_reg     <= '0;
            k_reg         <= '0;
            any_reg       <= 1'b0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            present_reg   <= present_next;
            ended_reg     <= ended_next;
            k_reg         <= k_next;
            any_reg       <= any_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_val_reg <= best_val_next;
        best_idx_reg <= best_idx_next;
        if (out_load)
        begin
            out_val_reg  <= out_val_new;
            out_src_reg  <= out_src_new;
            out_done_reg <= done_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_src_reg, out_val_reg};
    assign m_tuser  = out_done_reg;

endmodule

// File: sv/k_way_sorted_merge.sv
// Flow: an accepted item waits in the front-end queue; the back end pops it in IDLE, then in
// CHECK sees whether every list in use has a head or has ended. If not, it returns to IDLE
// with no result; if no head is left, it emits a done result (EMIT); else it scans the head
// RAM with the single comparator, one slot per cycle (SCAN), then emits the smallest head.
// The back end takes one item at a time; the queue keeps accepting items until it is full.
// Reset: flags, queue and output clear at once; lists_in_use returns to 8;
// head values are not cleared.
module k_way_sorted_merge
    import kwm_pkg::*;
#(
    parameter int NUM_LISTS   = DEF_NUM_LISTS,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // list_index[2:0], element_value[34:3], zeros
    input  logic               s_tlast,   // end_of_list
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // merged_value[31:0], source_list[34:32], zeros
    output logic               m_tuser,   // merge_done
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [3:0] lists_reg;
    logic [3:0] active_count;
    logic       cfg_write;
    kwm_item_t  item;
    logic       item_valid;
    logic       item_pop;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_LISTS_IN_USE);
    assign prdata    = (paddr[2] == REG_LISTS_IN_USE) ? {28'b0, lists_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lists_reg <= LISTS_RESET;
        end
        else if (cfg_write)
        begin
            lists_reg <= pwdata[3:0];
        end
    end

    always_comb
    begin
        if (lists_reg == '0)
        begin
            active_count = 4'd1;
        end
        else if (int'(lists_reg) > NUM_LISTS)
        begin
            active_count = 4'(NUM_LISTS);
        end
        else
        begin
            active_count = lists_reg;
        end
    end

    kwm_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .active_count (active_count),
        .item         (item),
        .item_valid   (item_valid),
        .item_pop     (item_pop)
    );

    kwm_back #(
        .NUM_LISTS   (NUM_LISTS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .item_valid   (item_valid),
        .item_pop     (item_pop),
        .active_count (active_count),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser)
    );

endmodule

// File: tb/sv/k_way_sorted_merge_tb.sv
`timescale 1ns / 100ps
// Testbench for k_way_sorted_merge: streams list heads and end markers, predicts every
// merged or done result and checks them in order. Depends on kwm_pkg and the block only.
module k_way_sorted_merge_tb
    import kwm_pkg::*;
;

    localparam int NLISTS     = DEF_NUM_LISTS;
    localparam int WDOG_LIMIT = 3000;
    localparam int HOLD_CYC   = 400;
    localparam int QUIET_CYC  = 30;
    localparam int PHASE_ITEMS = 85;

    typedef struct packed {
        logic [NLISTS-1:0][31:0] head;
        logic [NLISTS-1:0]       present;
        logic [NLISTS-1:0]       ended;
        logic [3:0]              lists;
    } merge_state_t;

    typedef struct packed {
        logic [31:0] value;
        logic [2:0]  src;
        logic        done;
    } merge_out_t;

    typedef struct packed {
        logic [2:0]  idx;
        logic [31:0] val;
        logic        eol;
    } list_item_t;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata;   // list_index[2:0], element_value[34:3], zeros
    logic               s_tlast;   // end_of_list
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;   // merged_value[31:0], source_list[34:32], zeros
    logic               m_tuser;   // merge_done
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    k_way_sorted_merge DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    list_item_t   pending_items[$];
    merge_out_t   merge_expect[$];
    merge_state_t check_st;
    merge_state_t plan_st;
    int           errors;
    int           phase_items;
    int           send_idle_pct;
    int           recv_idle_pct;
    int           hold_left;
    bit           hold_req;
    bit           took;
    int           quiet_cnt;
    merge_out_t   got_res;
    merge_out_t   want_res;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic bit merge_step(inout merge_state_t st, input logic [2:0] idx,
                                      input logic [31:0] val, input logic eol,
                                      output merge_out_t res);
        int  n;
        int  best;
        bit  ready;
        bit  any_head;
        n = (st.lists == 0) ? 1 : ((st.lists > NLISTS) ? NLISTS : int'(st.lists));
        best = 0;
        ready = 1'b1;
        any_head = 1'b0;
        res = '0;
        if (int'(idx) < n && !st.ended[idx])
        begin
            if (eol)
                st.ended[idx] = 1'b1;
            else if (!st.present[idx])
            begin
                st.head[idx] = val;
                st.present[idx] = 1'b1;
            end
        end
        for (int i = 0; i < n; i++)
        begin
            if (st.present[i])
            begin
                if (!any_head || $signed(st.head[i]) < $signed(st.head[best]))
                    best = i;
                any_head = 1'b1;
            end
            else if (!st.ended[i])
                ready = 1'b0;
        end
        if (!ready)
            return 1'b0;
        if (!any_head)
        begin
            st.present = '0;
            st.ended = '0;
            res.done = 1'b1;
            return 1'b1;
        end
        res.value = st.head[best];
        res.src = best[2:0];
        st.present[best] = 1'b0;
        return 1'b1;
    endfunction

    function automatic int active_lists(logic [3:0] lists);
        return (lists == 0) ? 1 : ((lists > NLISTS) ? NLISTS : int'(lists));
    endfunction

    task automatic plan_item(input logic [2:0] idx, input logic [31:0] val, input logic eol,
                             output bit done);
        merge_out_t r;
        bit         got;
        pending_items.insert(pending_items.size(), list_item_t'{idx, val, eol});
        phase_items++;
        got = merge_step(plan_st, idx, val, eol, r);
        done = got && r.done;
    endtask

    // one complete merge: non-decreasing lists with random content, plus some stray items
    task automatic plan_merge(input int max_len);
        longint   last_val[NLISTS];
        int       left[NLISTS];
        int       free_ids[$];
        int       n;
        int       pick;
        longint   nxt;
        bit       done;
        n = active_lists(plan_st.lists);
        done = 1'b0;
        for (int i = 0; i < NLISTS; i++)
        begin
            left[i] = $urandom_range(max_len);
            case ($urandom_range(3))
                0: last_val[i] = -64'sd2147483648 + $urandom_range(20);
                1: last_val[i] = 64'sd2147483647 - $urandom_range(200);
                default: last_val[i] = longint'(int'($urandom)) / ($urandom_range(1) ? 1 : 4096);
            endcase
        end
        while (!done)
        begin
            if ($urandom_range(99) < 8)
            begin
                plan_item(3'($urandom_range(NLISTS - 1)), $urandom, $urandom_range(9) == 0,
                          done);
                continue;
            end
            free_ids.delete();
            for (int i = 0; i < n; i++)
                if (!plan_st.present[i] && !plan_st.ended[i])
                    free_ids.insert(free_ids.size(), i);
            pick = free_ids[$urandom_range(free_ids.size() - 1)];
            case ($urandom_range(3))
                0: nxt = last_val[pick];
                1: nxt = last_val[pick] + $urandom_range(16);
                2: nxt = last_val[pick] + $urandom_range(1 << 20);
                default: nxt = last_val[pick] + longint'($urandom);
            endcase
            if (left[pick] == 0 || nxt > 64'sd2147483647)
                plan_item(pick[2:0], $urandom, 1'b1, done);
            else
            begin
                last_val[pick] = nxt;
                left[pick]--;
                plan_item(pick[2:0], nxt[31:0], 1'b0, done);
            end
        end
    endtask

    task automatic write_lists(input logic [3:0] lists);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(REG_LISTS_IN_USE) << 2;
        pwdata  <= {28'd0, lists};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        check_st.lists = lists;
        plan_st.lists  = lists;
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || merge_expect.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYC) @(posedge clk);
    endtask

    // sender: hold an offered transaction until taken, else offer the next or idle
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && !took)
                s_tvalid <= 1'b1;
            else if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= {{(TDATA_W-35){1'b0}}, pending_items[0].val, pending_items[0].idx};
                s_tlast  <= pending_items[0].eol;
            end
            else
                s_tvalid <= 1'b0;
            took = 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYC;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            void'(pending_items.pop_front());
            took = 1'b1;
            if (merge_step(check_st, s_tdata[2:0], s_tdata[34:3], s_tlast, want_res))
                merge_expect.insert(merge_expect.size(), want_res);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_res = '{value: m_tdata[31:0], src: m_tdata[34:32], done: m_tuser};
            if (merge_expect.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %h/%0d/%0d",
                         $time, got_res.value, got_res.src, got_res.done);
            end
            else
            begin
                want_res = merge_expect.pop_front();
                if (got_res !== want_res)
                begin
                    errors++;
                    $display("%0t: result mismatch, expected %h/%0d/%0d, actual %h/%0d/%0d",
                             $time, want_res.value, want_res.src, want_res.done,
                             got_res.value, got_res.src, got_res.done);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cnt <= 0;
        else if (quiet_cnt >= WDOG_LIMIT)
        begin
            $display("[k_way_sorted_merge] ERROR");
            $finish;
        end
        else
            quiet_cnt <= quiet_cnt + 1;
    end

    initial
    begin
        logic [3:0] phase_lists[12] = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd5, 4'd2,
                                        4'd8, 4'd7, 4'd3, 4'd4, 4'd6, 4'd8};
        bit done;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        phase_items = 0;
        hold_left = 0;
        hold_req = 1'b0;
        took = 1'b0;
        quiet_cnt = 0;
        send_idle_pct = 11;
        recv_idle_pct = 67;
        check_st = '0;
        check_st.lists = LISTS_RESET;
        plan_st = check_st;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // extremes, ties, stray and repeated items, then every list empty
        write_lists(4'd3);
        plan_item(3'd0, 32'h7FFFFFFF, 1'b0, done);
        plan_item(3'd5, 32'h00000011, 1'b0, done);
        plan_item(3'd7, 32'hFFFFFFFF, 1'b0, done);
        plan_item(3'd4, 32'h00000000, 1'b1, done);
        plan_item(3'd1, 32'h80000000, 1'b0, done);
        plan_item(3'd1, 32'h00000005, 1'b0, done);
        plan_item(3'd2, 32'h80000000, 1'b0, done);
        plan_item(3'd1, 32'h00000000, 1'b1, done);
        plan_item(3'd1, 32'h00000003, 1'b0, done);
        plan_item(3'd2, 32'hFFFFFFFF, 1'b0, done);
        plan_item(3'd2, 32'h00000000, 1'b1, done);
        plan_item(3'd0, 32'h00000000, 1'b1, done);
        plan_item(3'd0, 32'h00000000, 1'b1, done);
        plan_item(3'd1, 32'h00000000, 1'b1, done);
        plan_item(3'd2, 32'h00000000, 1'b1, done);
        plan_item(3'd0, 32'h00000009, 1'b0, done);
        plan_item(3'd2, 32'h00000009, 1'b0, done);
        plan_item(3'd1, 32'h00000009, 1'b0, done);
        plan_item(3'd0, 32'h00000000, 1'b1, done);
        plan_item(3'd1, 32'hDEADBEEF, 1'b1, done);
        plan_item(3'd2, 32'h00000000, 1'b1, done);
        drain();

        for (int p = 0; p < 12; p++)
        begin
            send_idle_pct = (p < 4) ? 11 : ((p < 8) ? 67 : 0);
            recv_idle_pct = (p < 4) ? 67 : ((p < 8) ? 11 : 0);
            write_lists(phase_lists[p]);
            if (p == 9)
                hold_req = 1'b1;
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
                plan_merge(($urandom_range(9) == 0) ? 20 : 6);
            drain();
        end

        if (errors == 0)
            $display("[k_way_sorted_merge] OK");
        else
            $display("[k_way_sorted_merge] ERROR");
        $finish;
    end

endmodule
